[src/fpba_pkg.sv]
// Package for the fit-policy block allocator: sizes, codes, table entry layout
// and the control/result structs passed between the sequencer and the fit unit.
// No dependencies.
package fpba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int SIZE_BITS  = 16;
    localparam int OWNER_BITS = 8;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // fit policy codes; the unused code behaves as first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // configuration register indexes
    localparam logic CFG_FIT_POLICY = 1'b0;
    localparam logic CFG_POOL_SIZE  = 1'b1;

    localparam logic [SIZE_BITS-1:0] POOL_RESET = {SIZE_BITS{1'b1}};

    typedef struct packed {
        logic [SIZE_BITS-1:0]  offset;
        logic [SIZE_BITS-1:0]  size;
        logic                  free;
        logic [OWNER_BITS-1:0] owner;
    } t_entry;

    typedef struct packed {
        logic                 clear;
        logic                 vld;
        logic [IDX_W-1:0]     idx;
        logic [1:0]           policy;
        logic [SIZE_BITS-1:0] req;
    } t_fit_ctl;

    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] offset;
        logic [SIZE_BITS-1:0] size;
    } t_fit_res;

endpackage

[src/fpba_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fpba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 41
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/fpba_fit.sv]
// Fit unit: judges one table entry per cycle against the request and keeps
// the running pick for the active policy. Depends on fpba_pkg.
module fpba_fit import fpba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fit_ctl i_ctl,
    input  t_entry   i_entry,
    output t_fit_res o_res
);

    t_fit_res             r_res;
    logic [SIZE_BITS-1:0] r_diff;
    logic [SIZE_BITS-1:0] diff;
    logic                 fits;
    logic                 take;

    assign fits = i_ctl.vld && i_entry.free && (i_entry.size >= i_ctl.req);
    assign diff = i_entry.size - i_ctl.req;

    always_comb begin
        take = 1'b0;
        if (fits) begin
            priority if (!r_res.found) begin
                take = 1'b1;
            end else if (i_ctl.policy == POL_BEST) begin
                take = (diff < r_diff);
            end else if (i_ctl.policy == POL_WORST) begin
                take = (diff > r_diff);
            end else begin
                // first fit keeps the earliest pick
                take = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_res.found <= 1'b0;
        end else if (take) begin
            r_res.found  <= 1'b1;
            r_res.idx    <= i_ctl.idx;
            r_res.offset <= i_entry.offset;
            r_res.size   <= i_entry.size;
            r_diff       <= diff;
        end
    end

    assign o_res = r_res;

endmodule

[src/fit_policy_block_allocator.sv]
// Top level of the fit-policy block allocator: sequencer around the block table
// RAM and the fit unit. Depends on fpba_pkg, fpba_ram, fpba_fit.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   tdata: owner_id, request_size
//  m_axis   out  m_axis_tvalid / m_axis_tready   tdata: status, granted_offset
//  cfg      in   i_cfg_we                        i_cfg_idx, i_cfg_data
//
// Sequence: the scan reads every entry once through the read pipeline, where N is
// the entry count (1..64); a miss or full table then ends the request, an exact fit
// writes only the pick, and a split first moves the N-1-pick entries above the pick
// up one slot per cycle, then writes the remainder and the pick.
// Reset: synchronous, active low; after reset (and after any pool_size write)
// the S_INIT state writes entry 0 as the single free block.
// Stalls: input is taken only while the sequencer is idle; a held result in the
// output register does not block intake, only the next result's delivery.
module fit_policy_block_allocator import fpba_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // [7:0] owner_id, [23:8] request_size
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,  // [1:0] status, [17:2] granted_offset,
                                                // [23:18] zero
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [SIZE_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WRREM, S_WRPICK, S_DONE
    } t_state;

    t_state                r_state;
    logic [1:0]            r_policy;
    logic [SIZE_BITS-1:0]  r_pool;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_idx;       // scan read pointer
    logic                  r_rd_vld;    // scan read data valid this cycle
    logic [IDX_W-1:0]      r_rd_idx;
    logic [CNT_W-1:0]      r_mv;        // shift read pointer, walks down
    logic                  r_sh_vld;    // shift read data valid this cycle
    logic [IDX_W-1:0]      r_sh_dst;
    logic [OWNER_BITS-1:0] r_owner;
    logic [SIZE_BITS-1:0]  r_req;
    logic [1:0]            r_status;
    logic [SIZE_BITS-1:0]  r_offset;
    logic                  r_m_valid;
    logic [1:0]            r_m_status;
    logic [SIZE_BITS-1:0]  r_m_offset;

    logic                  accept;
    logic                  scan_more;
    logic                  shift_more;
    logic                  need_split;
    logic                  out_free;
    logic                  pool_wr;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    t_entry                ram_rdata;

    t_fit_ctl              fit_ctl;
    t_fit_res              fit_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign pool_wr       = i_cfg_we && (i_cfg_idx == CFG_POOL_SIZE);

    assign scan_more  = (r_idx < r_count);
    assign shift_more = (r_mv > {{(CNT_W-IDX_W){1'b0}}, fit_res.idx});
    // the pick is at least the request; an exact fit only skips the split
    // when the request is nonzero
    assign need_split = (fit_res.size != r_req) || (r_req == '0);

    // RAM read port: scan walks up, shift walks down from the top entry
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_idx[IDX_W-1:0];
        if (r_state == S_SCAN) begin
            ram_re = scan_more;
        end else if (r_state == S_SHIFT) begin
            ram_re    = shift_more;
            ram_raddr = r_mv[IDX_W-1:0];
        end
    end

    // RAM write port; a shift writes slot j+1 while slot j-1 is being read,
    // so the two ports never meet on one entry
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '{offset: '0, size: r_pool, free: 1'b1, owner: '0};
            end
            S_SHIFT: begin
                ram_we    = r_sh_vld;
                ram_waddr = r_sh_dst;
            end
            S_WRREM: begin
                ram_we    = 1'b1;
                ram_waddr = fit_res.idx + IDX_W'(1);
                ram_wdata = '{offset: fit_res.offset + r_req,
                              size:   fit_res.size - r_req,
                              free:   1'b1,
                              owner:  '0};
            end
            S_WRPICK: begin
                ram_we    = 1'b1;
                ram_waddr = fit_res.idx;
                ram_wdata = '{offset: fit_res.offset, size: r_req, free: 1'b0,
                              owner: r_owner};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    fpba_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign fit_ctl = '{clear:  accept,
                       vld:    (r_state == S_SCAN) && r_rd_vld,
                       idx:    r_rd_idx,
                       policy: r_policy,
                       req:    r_req};

    fpba_fit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fit_ctl),
        .i_entry (ram_rdata),
        .o_res   (fit_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_policy  <= POL_FIRST;
            r_pool    <= POOL_RESET;
            r_count   <= CNT_W'(1);
            r_rd_vld  <= 1'b0;
            r_sh_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            // output register: load from S_DONE, otherwise drain on tready
            if ((r_state == S_DONE) && out_free && !pool_wr) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            // a pool write re-forms the table; the user must send configuration only while idle (not enforced)
            if (pool_wr) begin
                r_state <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        r_count <= CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (accept) begin
                            r_owner  <= s_axis_tdata[OWNER_BITS-1:0];
                            r_req    <= s_axis_tdata[OWNER_BITS +: SIZE_BITS];
                            r_idx    <= '0;
                            r_rd_vld <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                    S_SCAN: begin
                        r_rd_vld <= scan_more;
                        r_rd_idx <= r_idx[IDX_W-1:0];
                        if (scan_more) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end else if (!r_rd_vld) begin
                            r_state <= S_DECIDE;
                        end
                    end
                    S_DECIDE: begin
                        r_offset <= '0;
                        priority if (!fit_res.found) begin
                            r_status <= STAT_NOFIT;
                            r_state  <= S_DONE;
                        end else if (need_split && (r_count == CNT_W'(MAX_BLOCKS))) begin
                            r_status <= STAT_FULL;
                            r_state  <= S_DONE;
                        end else if (need_split) begin
                            r_mv     <= r_count - CNT_W'(1);
                            r_sh_vld <= 1'b0;
                            r_state  <= S_SHIFT;
                        end else begin
                            r_state <= S_WRPICK;
                        end
                    end
                    S_SHIFT: begin
                        r_sh_vld <= shift_more;
                        r_sh_dst <= IDX_W'(r_mv + CNT_W'(1));
                        if (shift_more) begin
                            r_mv <= r_mv - CNT_W'(1);
                        end else if (!r_sh_vld) begin
                            r_state <= S_WRREM;
                        end
                    end
                    S_WRREM: begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_WRPICK;
                    end
                    S_WRPICK: begin
                        r_status <= STAT_OK;
                        r_offset <= fit_res.offset;
                        r_state  <= S_DONE;
                    end
                    S_DONE: begin
                        if (out_free) begin
                            r_m_status <= r_status;
                            r_m_offset <= r_offset;
                            r_state    <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIT_POLICY) begin
                    r_policy <= i_cfg_data[1:0];
                end else if (i_cfg_idx == CFG_POOL_SIZE) begin
                    r_pool <= i_cfg_data;
                end
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_offset, r_m_status};

endmodule

[src/fpba_checker.sv]
// Port-level checker for the fit-policy block allocator, bound to the top level.
// Depends on fit_policy_block_allocator.
module fpba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[23:18] == 6'd0))
        else $error("bad status code or padding");

    // failed requests report offset zero
    a_fail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0) |-> (m_axis_tdata[17:2] == 16'd0))
        else $error("nonzero offset on failed request");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
